// ===== hw/rtl/mtp3rt_pkg.sv =====
package mtp3rt_pkg;

  // Table size and point code width
  localparam int unsigned RULE_COUNT      = 16;
  localparam int unsigned POINT_CODE_BITS = 24;

  // Fixed field widths of the channels
  localparam int unsigned OPCODE_W   = 2;
  localparam int unsigned MASK_W     = 3;
  localparam int unsigned FIELD_PC_W = 24;
  localparam int unsigned SVC_W      = 8;
  localparam int unsigned RULES_W    = 5;

  // Point codes keep their low POINT_CODE_BITS bits, never more than the field
  localparam int unsigned PC_W  = (POINT_CODE_BITS < FIELD_PC_W) ? POINT_CODE_BITS : FIELD_PC_W;
  localparam int unsigned IDX_W = (RULE_COUNT > 1) ? $clog2(RULE_COUNT) : 1;
  localparam int unsigned CNT_W = $clog2(RULE_COUNT + 1);

  // Opcodes
  localparam logic [OPCODE_W-1:0] OP_CLASSIFY = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_APPEND   = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_CLEAR    = 2'd2;

  // Compare enable bits of a rule
  localparam int unsigned CMP_ORIGIN_BIT  = 0;
  localparam int unsigned CMP_DEST_BIT    = 1;
  localparam int unsigned CMP_SERVICE_BIT = 2;

  typedef struct packed {
    logic [OPCODE_W-1:0]   opcode;
    logic [MASK_W-1:0]     compare_mask;
    logic [FIELD_PC_W-1:0] origin_point;
    logic [FIELD_PC_W-1:0] destination_point;
    logic [SVC_W-1:0]      service_info;
  } item_t;

  typedef struct packed {
    logic               matched;
    logic               status;
    logic [RULES_W-1:0] rules_in_table;
  } result_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;    // latch the accepted transaction, restart the scan
    logic scan_step;  // read one rule, advance the scan index
    logic finish;     // apply the item and load the result register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_needed;  // incoming transaction is a classify on a non-empty table
    logic scan_last;    // scan index sits on the last held rule
    logic out_free;     // result register can take a new result
  } sts_t;

endpackage

// ===== hw/rtl/mtp3rt_if.sv =====
interface mtp3rt_item_if;
  logic                                valid;
  logic                                ready;
  logic [mtp3rt_pkg::OPCODE_W-1:0]     opcode;
  logic [mtp3rt_pkg::MASK_W-1:0]       compare_mask;
  logic [mtp3rt_pkg::FIELD_PC_W-1:0]   origin_point;
  logic [mtp3rt_pkg::FIELD_PC_W-1:0]   destination_point;
  logic [mtp3rt_pkg::SVC_W-1:0]        service_info;

  modport source (
    output valid, opcode, compare_mask, origin_point, destination_point, service_info,
    input  ready
  );
  modport sink (
    input  valid, opcode, compare_mask, origin_point, destination_point, service_info,
    output ready
  );
endinterface

interface mtp3rt_result_if;
  logic                             valid;
  logic                             ready;
  logic                             matched;
  logic                             status;
  logic [mtp3rt_pkg::RULES_W-1:0]   rules_in_table;

  modport source (
    output valid, matched, status, rules_in_table,
    input  ready
  );
  modport sink (
    input  valid, matched, status, rules_in_table,
    output ready
  );
endinterface

// ===== hw/rtl/mtp3rt_datapath.sv =====
module mtp3rt_datapath (
  input  logic                clk,
  input  logic                rst,
  input  mtp3rt_pkg::item_t   item_data,
  input  mtp3rt_pkg::cmd_t    cmd,
  output mtp3rt_pkg::sts_t    sts,
  output logic                result_valid,
  input  logic                result_ready,
  output mtp3rt_pkg::result_t result_data
);

  typedef struct packed {
    logic [mtp3rt_pkg::MASK_W-1:0] mask;
    logic [mtp3rt_pkg::PC_W-1:0]   origin;
    logic [mtp3rt_pkg::PC_W-1:0]   dest;
    logic [mtp3rt_pkg::SVC_W-1:0]  service;
  } rule_t;

  function automatic logic rule_hit(
    input rule_t                          r,
    input logic [mtp3rt_pkg::PC_W-1:0]    org,
    input logic [mtp3rt_pkg::PC_W-1:0]    dst,
    input logic [mtp3rt_pkg::SVC_W-1:0]   svc
  );
    logic org_ok;
    logic dst_ok;
    logic svc_ok;
    org_ok = !r.mask[mtp3rt_pkg::CMP_ORIGIN_BIT]  || (r.origin == org);
    dst_ok = !r.mask[mtp3rt_pkg::CMP_DEST_BIT]    || (r.dest == dst);
    svc_ok = !r.mask[mtp3rt_pkg::CMP_SERVICE_BIT] || (r.service == svc);
    return org_ok && dst_ok && svc_ok;
  endfunction

  rule_t                              mem [mtp3rt_pkg::RULE_COUNT];
  rule_t                              rd_data;
  rule_t                              new_rule;
  logic                               rd_pend;
  logic                               match_acc;
  mtp3rt_pkg::item_t                  cur;
  logic [mtp3rt_pkg::CNT_W-1:0]       total;
  logic [mtp3rt_pkg::CNT_W-1:0]       total_next;
  logic [mtp3rt_pkg::IDX_W-1:0]       scan_idx;
  logic                               full;
  logic                               wr_en;
  logic                               is_classify;
  logic                               is_append;
  logic                               is_clear;

  assign full        = (total == mtp3rt_pkg::CNT_W'(mtp3rt_pkg::RULE_COUNT));
  assign is_classify = (cur.opcode == mtp3rt_pkg::OP_CLASSIFY);
  assign is_append   = (cur.opcode == mtp3rt_pkg::OP_APPEND);
  assign is_clear    = (cur.opcode == mtp3rt_pkg::OP_CLEAR);
  assign wr_en       = cmd.finish && is_append && !full;

  assign new_rule.mask    = cur.compare_mask;
  assign new_rule.origin  = cur.origin_point[mtp3rt_pkg::PC_W-1:0];
  assign new_rule.dest    = cur.destination_point[mtp3rt_pkg::PC_W-1:0];
  assign new_rule.service = cur.service_info;

  always_comb begin
    total_next = total;
    if (wr_en) begin
      total_next = total + mtp3rt_pkg::CNT_W'(1);
    end else if (is_clear) begin
      total_next = '0;
    end
  end

  assign sts.scan_needed = (item_data.opcode == mtp3rt_pkg::OP_CLASSIFY) && (total != '0);
  assign sts.scan_last   = (mtp3rt_pkg::CNT_W'(scan_idx) == (total - mtp3rt_pkg::CNT_W'(1)));
  assign sts.out_free    = !result_valid || result_ready;

  // Rule memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[total[mtp3rt_pkg::IDX_W-1:0]] <= new_rule;
    end
    if (cmd.scan_step) begin
      rd_data <= mem[scan_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur <= item_data;
    end
    if (cmd.finish) begin
      result_data.matched        <= is_classify && match_acc;
      result_data.status         <= is_append && full;
      result_data.rules_in_table <= mtp3rt_pkg::RULES_W'(total_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total        <= '0;
      scan_idx     <= '0;
      rd_pend      <= 1'b0;
      match_acc    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      rd_pend <= cmd.scan_step;
      if (cmd.capture) begin
        scan_idx  <= '0;
        match_acc <= 1'b0;
      end else begin
        if (cmd.scan_step) begin
          scan_idx <= scan_idx + mtp3rt_pkg::IDX_W'(1);
        end
        if (rd_pend && rule_hit(rd_data, cur.origin_point[mtp3rt_pkg::PC_W-1:0],
                                cur.destination_point[mtp3rt_pkg::PC_W-1:0],
                                cur.service_info)) begin
          match_acc <= 1'b1;
        end
      end
      if (cmd.finish) begin
        total        <= total_next;
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/mtp3rt_ctrl.sv =====
module mtp3rt_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  mtp3rt_pkg::sts_t sts,
  output mtp3rt_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_FLUSH  = 4'b0100,
    ST_REPORT = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next    = state;
    item_ready    = 1'b0;
    cmd.capture   = 1'b0;
    cmd.scan_step = 1'b0;
    cmd.finish    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        // hold off the input while reset is applied
        item_ready = !rst;
        if (item_valid && !rst) begin
          cmd.capture = 1'b1;
          state_next  = sts.scan_needed ? ST_SCAN : ST_REPORT;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        // last read compares this cycle
        state_next = ST_REPORT;
      end
      ST_REPORT: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hw/rtl/mtp3_rule_table_classifier_unit.sv =====
// Sequence: a classify on a non-empty table scans the held rules, lets the last
//   read compare, then reports; append, clear and an empty-table classify report
//   directly. A new transaction is taken once the last is in the result register.
// Throughput: one rule read per cycle from the single read port of the rule memory.
// Reset (rst, synchronous, active high): empties the table and the result register;
//   rule memory contents are left as they are and only held rules are ever read.
module mtp3_rule_table_classifier_unit (
  input  logic                   clk,
  input  logic                   rst,
  mtp3rt_item_if.sink            item,
  mtp3rt_result_if.source        result
);

  mtp3rt_pkg::cmd_t    cmd;
  mtp3rt_pkg::sts_t    sts;
  mtp3rt_pkg::item_t   item_data;
  mtp3rt_pkg::result_t result_data;
  logic                item_ready;
  logic                result_valid;

  // Gather the incoming transaction payload
  assign item_data.opcode            = item.opcode;
  assign item_data.compare_mask      = item.compare_mask;
  assign item_data.origin_point      = item.origin_point;
  assign item_data.destination_point = item.destination_point;
  assign item_data.service_info      = item.service_info;

  // Controller sequences one transaction at a time: accept, scan the held rules,
  // let the last read compare, then report into the result register.
  mtp3rt_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Datapath holds the rule memory, rule count, scan index, match accumulator
  // and the result register that parts the input side from the output side.
  mtp3rt_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .item_data    (item_data),
    .cmd          (cmd),
    .sts          (sts),
    .result_valid (result_valid),
    .result_ready (result.ready),
    .result_data  (result_data)
  );

  assign item.ready            = item_ready;
  assign result.valid          = result_valid;
  assign result.matched        = result_data.matched;
  assign result.status         = result_data.status;
  assign result.rules_in_table = result_data.rules_in_table;

  // A new result appears only where the controller finished an item
  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(cmd.finish))
    else $error("result raised without a finished item");

  // Never take a new transaction while the scan is reading rules
  a_no_accept_in_scan: assert property (@(posedge clk) disable iff (rst)
    !(item_ready && cmd.scan_step))
    else $error("input ready during rule scan");

  // Items that need no scan go straight to report
  a_no_scan_when_unneeded: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item_ready && !sts.scan_needed) |=> !cmd.scan_step)
    else $error("rule scan started for an item that needs none");

  // Finish only when the result register can take the result
  a_finish_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> sts.out_free)
    else $error("result overwritten before it was taken");

endmodule

// ===== tb/mtp3_rule_table_classifier_unit_test.sv =====
module mtp3_rule_table_classifier_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD  = 5;
  localparam int RESET_CYCLES = 4;
  localparam int RANDOM_ITEMS = 1080;
  // The final stretch of the run goes without any idling on either side.
  localparam int CALM_ITEMS   = 150;
  // Long receiver hold-off: the result register fills and the input stalls.
  localparam int LONG_HOLD    = 300;
  localparam int HOLD_AT      = 300;
  // Sender waits here until every outstanding verdict has come back.
  localparam int PAUSE_AT     = 600;
  // Slowest item is a classify over a full table.
  localparam int DRAIN_CYCLES = mtp3rt_pkg::RULE_COUNT + 8;
  // Longest correct gap between transactions is the long hold-off plus a scan.
  localparam int STALL_LIMIT  = 4 * (LONG_HOLD + 2 * mtp3rt_pkg::RULE_COUNT + 40);

  // Opcode 3 carries no operation; the block must leave its state alone.
  localparam logic [mtp3rt_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;

  // Shadow of the rule table; every accepted transaction queues the verdict
  // the block owes for it, and every result pops the oldest one.
  class rule_table_tracker;
    logic [mtp3rt_pkg::MASK_W-1:0] rule_mask [mtp3rt_pkg::RULE_COUNT];
    logic [mtp3rt_pkg::PC_W-1:0]   rule_org  [mtp3rt_pkg::RULE_COUNT];
    logic [mtp3rt_pkg::PC_W-1:0]   rule_dst  [mtp3rt_pkg::RULE_COUNT];
    logic [mtp3rt_pkg::SVC_W-1:0]  rule_svc  [mtp3rt_pkg::RULE_COUNT];
    int unsigned                   rule_total;
    mtp3rt_pkg::result_t           pending_verdicts [$];
    int unsigned                   mismatches;

    function new();
      rule_total = 0;
      mismatches = 0;
    endfunction

    function void note_transaction(mtp3rt_pkg::item_t t);
      mtp3rt_pkg::result_t         r;
      bit                          hit_rule;
      logic [mtp3rt_pkg::PC_W-1:0] org;
      logic [mtp3rt_pkg::PC_W-1:0] dst;
      r   = '0;
      org = t.origin_point[mtp3rt_pkg::PC_W-1:0];
      dst = t.destination_point[mtp3rt_pkg::PC_W-1:0];
      case (t.opcode)
        mtp3rt_pkg::OP_CLASSIFY: begin
          // OR over every held rule, no early exit on a miss
          for (int i = 0; i < rule_total; i++) begin
            hit_rule = 1'b1;
            if (rule_mask[i][mtp3rt_pkg::CMP_ORIGIN_BIT] && rule_org[i] != org)
              hit_rule = 1'b0;
            if (rule_mask[i][mtp3rt_pkg::CMP_DEST_BIT] && rule_dst[i] != dst)
              hit_rule = 1'b0;
            if (rule_mask[i][mtp3rt_pkg::CMP_SERVICE_BIT] && rule_svc[i] != t.service_info)
              hit_rule = 1'b0;
            if (hit_rule) r.matched = 1'b1;
          end
        end
        mtp3rt_pkg::OP_APPEND: begin
          if (rule_total >= mtp3rt_pkg::RULE_COUNT) begin
            r.status = 1'b1;
          end else begin
            rule_mask[rule_total] = t.compare_mask;
            rule_org[rule_total]  = org;
            rule_dst[rule_total]  = dst;
            rule_svc[rule_total]  = t.service_info;
            rule_total++;
          end
        end
        mtp3rt_pkg::OP_CLEAR: rule_total = 0;
        default: ;
      endcase
      r.rules_in_table = mtp3rt_pkg::RULES_W'(rule_total);
      pending_verdicts.insert(pending_verdicts.size(), r);
    endfunction

    function void check_verdict(mtp3rt_pkg::result_t got);
      mtp3rt_pkg::result_t want;
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result matched=%0d status=%0d rules=%0d",
                 $time, got.matched, got.status, got.rules_in_table);
        mismatches++;
        return;
      end
      want = pending_verdicts.pop_front();
      if (got.matched !== want.matched) begin
        $display("%0t: matched expected %0d actual %0d", $time, want.matched, got.matched);
        mismatches++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        mismatches++;
      end
      if (got.rules_in_table !== want.rules_in_table) begin
        $display("%0t: rules_in_table expected %0d actual %0d",
                 $time, want.rules_in_table, got.rules_in_table);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  mtp3rt_item_if   item_bus ();
  mtp3rt_result_if result_bus ();

  mtp3_rule_table_classifier_unit dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_bus),
    .result (result_bus)
  );

  rule_table_tracker tracker = new();

  // Handshake flags shared by the sender and the receiver.
  bit hold_request = 1'b0;
  bit calm         = 1'b0;

  // Recently appended field values, so classify traffic can aim at held rules.
  logic [mtp3rt_pkg::FIELD_PC_W-1:0] pool_org [mtp3rt_pkg::RULE_COUNT];
  logic [mtp3rt_pkg::FIELD_PC_W-1:0] pool_dst [mtp3rt_pkg::RULE_COUNT];
  logic [mtp3rt_pkg::SVC_W-1:0]      pool_svc [mtp3rt_pkg::RULE_COUNT];
  int unsigned                       pool_fill = 0;
  int unsigned                       pool_wr   = 0;

  always #HALF_PERIOD clk = ~clk;

  // Hold every input at a known value from time zero.
  initial begin
    item_bus.valid             = 1'b0;
    item_bus.opcode            = mtp3rt_pkg::OP_CLASSIFY;
    item_bus.compare_mask      = '0;
    item_bus.origin_point      = '0;
    item_bus.destination_point = '0;
    item_bus.service_info      = '0;
  end

  // Sample both channels at the rising edge; check before noting so that a
  // result and a new transaction on the same edge keep their order.
  always @(posedge clk) begin
    if (!rst) begin
      if (result_bus.valid === 1'b1 && result_bus.ready === 1'b1)
        tracker.check_verdict('{matched: result_bus.matched, status: result_bus.status,
                                rules_in_table: result_bus.rules_in_table});
      if (item_bus.valid === 1'b1 && item_bus.ready === 1'b1)
        tracker.note_transaction('{opcode: item_bus.opcode,
                                   compare_mask: item_bus.compare_mask,
                                   origin_point: item_bus.origin_point,
                                   destination_point: item_bus.destination_point,
                                   service_info: item_bus.service_info});
    end
  end

  // Watchdog: count cycles with no transaction on either channel.
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if ((item_bus.valid === 1'b1 && item_bus.ready === 1'b1) ||
        (result_bus.valid === 1'b1 && result_bus.ready === 1'b1))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("mtp3_rule_table_classifier_unit test failed");
      $finish;
    end
  end

  // Receiver: random ready bursts, one long hold-off on request, none when calm.
  initial begin
    result_bus.ready = 1'b0;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      if (hold_request) begin
        result_bus.ready = 1'b0;
        hold_request = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else if (calm) begin
        result_bus.ready = 1'b1;
        @(negedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        result_bus.ready = 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end else begin
        result_bus.ready = 1'b1;
        repeat ($urandom_range(1, 24)) @(negedge clk);
      end
    end
  end

  function automatic mtp3rt_pkg::item_t make_item(
    logic [mtp3rt_pkg::OPCODE_W-1:0]   op,
    logic [mtp3rt_pkg::MASK_W-1:0]     mask,
    logic [mtp3rt_pkg::FIELD_PC_W-1:0] org,
    logic [mtp3rt_pkg::FIELD_PC_W-1:0] dst,
    logic [mtp3rt_pkg::SVC_W-1:0]      svc
  );
    mtp3rt_pkg::item_t t;
    t.opcode            = op;
    t.compare_mask      = mask;
    t.origin_point      = org;
    t.destination_point = dst;
    t.service_info      = svc;
    return t;
  endfunction

  // Point codes lean toward the extremes now and then.
  function automatic logic [mtp3rt_pkg::FIELD_PC_W-1:0] pick_point();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return mtp3rt_pkg::FIELD_PC_W'($urandom);
  endfunction

  function automatic logic [mtp3rt_pkg::SVC_W-1:0] pick_service();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return mtp3rt_pkg::SVC_W'($urandom);
  endfunction

  // Random transaction: mostly appends and classifies aimed at held rules,
  // with near misses, occasional clears and the unused opcode.
  function automatic mtp3rt_pkg::item_t random_transaction();
    mtp3rt_pkg::item_t t;
    int unsigned       roll;
    int unsigned       pick;
    t = make_item(mtp3rt_pkg::OP_CLASSIFY, mtp3rt_pkg::MASK_W'($urandom), pick_point(),
                  pick_point(), pick_service());
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      t.opcode = mtp3rt_pkg::OP_CLEAR;
    end else if (roll < 6) begin
      t.opcode = OP_UNUSED;
    end else if (roll < 38) begin
      t.opcode = mtp3rt_pkg::OP_APPEND;
      // A rule that compares nothing matches everything; keep it uncommon.
      t.compare_mask = ($urandom_range(0, 15) == 0) ? '0 :
                       mtp3rt_pkg::MASK_W'($urandom_range(1, 7));
      pool_org[pool_wr] = t.origin_point;
      pool_dst[pool_wr] = t.destination_point;
      pool_svc[pool_wr] = t.service_info;
      pool_wr = (pool_wr + 1) % mtp3rt_pkg::RULE_COUNT;
      if (pool_fill < mtp3rt_pkg::RULE_COUNT) pool_fill++;
    end else if (pool_fill != 0 && $urandom_range(0, 9) < 7) begin
      pick = $urandom_range(0, pool_fill - 1);
      t.origin_point      = pool_org[pick];
      t.destination_point = pool_dst[pick];
      t.service_info      = pool_svc[pick];
      // Near miss: flip one bit of one field.
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 2))
          0: t.origin_point[$urandom_range(0, mtp3rt_pkg::FIELD_PC_W - 1)] ^= 1'b1;
          1: t.destination_point[$urandom_range(0, mtp3rt_pkg::FIELD_PC_W - 1)] ^= 1'b1;
          default: t.service_info[$urandom_range(0, mtp3rt_pkg::SVC_W - 1)] ^= 1'b1;
        endcase
      end
    end
    return t;
  endfunction

  // Offer one transaction starting at a falling edge; return at the falling
  // edge after it is taken.
  task automatic send_transaction(input mtp3rt_pkg::item_t t);
    item_bus.opcode            = t.opcode;
    item_bus.compare_mask      = t.compare_mask;
    item_bus.origin_point      = t.origin_point;
    item_bus.destination_point = t.destination_point;
    item_bus.service_info      = t.service_info;
    item_bus.valid             = 1'b1;
    @(posedge clk);
    while (item_bus.ready !== 1'b1) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic idle_sender(input int unsigned cycles);
    item_bus.valid = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic run_directed();
    // Empty table: nothing matches, and the unused opcode changes nothing.
    send_transaction(make_item(mtp3rt_pkg::OP_CLASSIFY, '0, '0, '0, '0));
    send_transaction(make_item(OP_UNUSED, '1, '1, '1, '1));
    // Full compare rule at all-ones, then a hit and a one-field miss.
    send_transaction(make_item(mtp3rt_pkg::OP_APPEND, 3'b111, '1, '1, '1));
    send_transaction(make_item(mtp3rt_pkg::OP_CLASSIFY, '0, '1, '1, '1));
    send_transaction(make_item(mtp3rt_pkg::OP_CLASSIFY, '1, '1, '1, 8'hFE));
    // Origin-only rule at zero; stored values of disabled fields are ignored.
    send_transaction(make_item(mtp3rt_pkg::OP_APPEND, 3'b001, '0, '1, '1));
    send_transaction(make_item(mtp3rt_pkg::OP_CLASSIFY, '0, '0, '0, '0));
    send_transaction(make_item(mtp3rt_pkg::OP_APPEND, 3'b010, '1, 24'h123456, '0));
    send_transaction(make_item(mtp3rt_pkg::OP_APPEND, 3'b100, 24'hABCDEF, '0, '0));
    send_transaction(make_item(mtp3rt_pkg::OP_APPEND, 3'b011, 24'h0F0F0F, 24'hF0F0F0,
                               8'h5A));
    send_transaction(make_item(mtp3rt_pkg::OP_APPEND, 3'b101, 24'h00FF00, '0, 8'h83));
    send_transaction(make_item(mtp3rt_pkg::OP_APPEND, 3'b110, '0, 24'h800001, 8'h03));
    send_transaction(make_item(mtp3rt_pkg::OP_CLASSIFY, '0, 24'h5A5A5A, 24'hA5A5A5,
                               8'h11));
    // Compare-nothing rule: every message matches until the table is cleared.
    send_transaction(make_item(mtp3rt_pkg::OP_APPEND, 3'b000, 24'h5A5A5A, 24'hA5A5A5,
                               8'h11));
    send_transaction(make_item(mtp3rt_pkg::OP_CLASSIFY, '0, 24'h5A5A5A, 24'hA5A5A5,
                               8'h11));
    // Fill the table, then one append too many is refused.
    for (int k = 0; k < 8; k++)
      send_transaction(make_item(mtp3rt_pkg::OP_APPEND,
                                 mtp3rt_pkg::MASK_W'($urandom_range(1, 7)), pick_point(),
                                 pick_point(), pick_service()));
    send_transaction(make_item(mtp3rt_pkg::OP_APPEND, 3'b111, '1, '0, '1));
    send_transaction(make_item(mtp3rt_pkg::OP_CLASSIFY, '0, '1, '0, '1));
    send_transaction(make_item(mtp3rt_pkg::OP_CLEAR, '0, '0, '0, '0));
  endtask

  initial begin
    int unsigned idle_odds;
    idle_odds = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    run_directed();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      // Change the sender's idle rate every fifty transactions, zero included.
      if (i % 50 == 0) begin
        case ($urandom_range(0, 2))
          0: idle_odds = 0;
          1: idle_odds = 12;
          default: idle_odds = 33;
        endcase
      end
      if (i == HOLD_AT) hold_request = 1'b1;
      if (i == PAUSE_AT) begin
        item_bus.valid = 1'b0;
        do @(negedge clk); while (tracker.pending_verdicts.size() != 0);
      end
      if (!calm && $urandom_range(0, 99) < idle_odds)
        idle_sender($urandom_range(1, 19));
      send_transaction(random_transaction());
    end
    item_bus.valid = 1'b0;

    // Drain: wait for every verdict, then give the block time to misbehave.
    while (tracker.pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending_verdicts.size() == 0)
      $display("mtp3_rule_table_classifier_unit test passed");
    else
      $display("mtp3_rule_table_classifier_unit test failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/mtp3rt_pkg.sv
hw/rtl/mtp3rt_if.sv
hw/rtl/mtp3rt_datapath.sv
hw/rtl/mtp3rt_ctrl.sv
hw/rtl/mtp3_rule_table_classifier_unit.sv
tb/mtp3_rule_table_classifier_unit_test.sv
